// File: hw/rtl/a85d_pkg.sv
// a85d_pkg: shared types, constants and helpers of the ascii85 decoder
// used by a85d_front, a85d_fifo, a85d_back and ascii85_decoder_unit
// no dependencies
package a85d_pkg;

  localparam logic [7:0] DigitLow  = 8'h21;
  localparam logic [7:0] DigitHigh = 8'h75;
  localparam logic [7:0] ZeroGroup = 8'h7A;
  localparam logic [6:0] PadDigit  = 7'(DigitHigh - DigitLow);
  localparam logic [2:0] GroupDigits = 3'd5;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrInvalid  = 2'd1,
    ErrOverflow = 2'd2,
    ErrLone     = 2'd3
  } err_code_e;

  typedef struct packed {
    err_code_e   err;
    logic [32:0] value;
    logic [1:0]  pad;
    logic        eos;
  } cmd_t;

  // v * 85 + d as shift-add, kept to 33 bits
  function automatic logic [32:0] mul85_add(input logic [32:0] v, input logic [6:0] d);
    logic [39:0] acc;
    acc = {1'b0, v, 6'b0} + {3'b0, v, 4'b0} + {5'b0, v, 2'b0} + {7'b0, v} + {33'b0, d};
    return acc[32:0];
  endfunction

endpackage

// File: hw/rtl/a85d_front.sv
// a85d_front: accepts characters, classifies them and accumulates base-85 groups
// pushes one command per result-producing character into the queue
// depends on a85d_pkg
module a85d_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     char_in_i,
  input  logic           end_of_stream_i,
  input  logic           q_full_i,
  output logic           push_o,
  output a85d_pkg::cmd_t cmd_o
);
  import a85d_pkg::*;

  logic [31:0] group_q, group_d;
  logic [2:0]  count_q, count_d;
  logic [2:0]  count_inc;
  logic [6:0]  digit;
  logic [32:0] acc;
  logic        accept;
  logic        is_digit;
  logic        is_zero;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign digit      = 7'(char_in_i - DigitLow);
  assign is_digit   = (char_in_i >= DigitLow) && (char_in_i <= DigitHigh);
  assign is_zero    = (char_in_i == ZeroGroup) && (count_q == 3'd0);
  assign count_inc  = count_q + 3'd1;
  assign acc        = mul85_add({1'b0, group_q}, digit);

  always_comb begin
    group_d   = group_q;
    count_d   = count_q;
    push_o    = 1'b0;
    cmd_o.err   = ErrNone;
    cmd_o.value = acc;
    cmd_o.pad   = 2'd0;
    cmd_o.eos   = end_of_stream_i;
    if (accept) begin
      priority if (is_zero) begin
        push_o      = 1'b1;
        cmd_o.value = '0;
        group_d     = '0;
        count_d     = '0;
      end else if (!is_digit) begin
        push_o      = 1'b1;
        cmd_o.err   = ErrInvalid;
        cmd_o.value = '0;
        group_d     = '0;
        count_d     = '0;
      end else if (count_inc == GroupDigits) begin
        push_o  = 1'b1;
        group_d = '0;
        count_d = '0;
      end else if (end_of_stream_i) begin
        push_o  = 1'b1;
        group_d = '0;
        count_d = '0;
        if (count_inc == 3'd1) begin
          cmd_o.err   = ErrLone;
          cmd_o.value = '0;
        end else begin
          cmd_o.pad = 2'(GroupDigits - count_inc);
        end
      end else begin
        group_d = acc[31:0];
        count_d = count_inc;
      end
      if (end_of_stream_i) begin
        group_d = '0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      count_q <= '0;
    end else begin
      group_q <= group_d;
      count_q <= count_d;
    end
  end

endmodule

// File: hw/rtl/a85d_fifo.sv
// a85d_fifo: short command queue between front and back end
// depends on a85d_pkg
module a85d_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  a85d_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output a85d_pkg::cmd_t cmd_o
);
  import a85d_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= QCntW'(QDepth))
    else $error("queue count out of range");

endmodule

// File: hw/rtl/a85d_back.sv
// a85d_back: pads end groups, checks overflow; emits one beat per cycle unless
// stalled by out_ready or padding; holds the output register; depends on a85d_pkg
module a85d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  a85d_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     data_byte_o,
  output logic [1:0]     error_code_o,
  output logic           last_of_run_o,
  output logic           stream_done_o
);
  import a85d_pkg::*;

  logic        cur_valid_q;
  err_code_e   cur_err_q;
  logic [32:0] cur_val_q;
  logic [1:0]  cur_pad_q;
  logic [1:0]  cur_idx_q;
  logic [1:0]  cur_last_idx_q;
  logic        cur_eos_q;

  logic        out_valid_q;
  logic [7:0]  out_data_q;
  err_code_e   out_err_q;
  logic        out_last_q;
  logic        out_done_q;

  logic        overflow;
  logic        single;
  logic        emit;
  logic        res_last;
  logic [7:0]  sel_byte;
  err_code_e   res_err;

  assign overflow = cur_val_q[32];
  assign single   = (cur_err_q != ErrNone) || overflow;
  assign emit     = cur_valid_q && (cur_pad_q == 2'd0) && (!out_valid_q || out_ready_i);
  assign res_last = single || (cur_idx_q == cur_last_idx_q);
  assign pop_o    = q_valid_i && (!cur_valid_q || (emit && res_last));

  always_comb begin
    unique case (cur_idx_q)
      2'd0:    sel_byte = cur_val_q[31:24];
      2'd1:    sel_byte = cur_val_q[23:16];
      2'd2:    sel_byte = cur_val_q[15:8];
      default: sel_byte = cur_val_q[7:0];
    endcase
    if (cur_err_q != ErrNone) begin
      res_err = cur_err_q;
    end else if (overflow) begin
      res_err = ErrOverflow;
    end else begin
      res_err = ErrNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
      end else if (emit && res_last) begin
        cur_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_err_q      <= cmd_i.err;
      cur_val_q      <= cmd_i.value;
      cur_pad_q      <= cmd_i.pad;
      cur_eos_q      <= cmd_i.eos;
      cur_idx_q      <= 2'd0;
      cur_last_idx_q <= 2'd3 - cmd_i.pad;
    end else begin
      if (cur_pad_q != 2'd0) begin
        cur_val_q <= mul85_add(cur_val_q, PadDigit);
        cur_pad_q <= cur_pad_q - 2'd1;
      end
      if (emit) begin
        cur_idx_q <= cur_idx_q + 2'd1;
      end
    end
    if (emit) begin
      out_data_q <= single ? 8'd0 : sel_byte;
      out_err_q  <= res_err;
      out_last_q <= res_last;
      out_done_q <= res_last && cur_eos_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_byte_o   = out_data_q;
  assign error_code_o  = out_err_q;
  assign last_of_run_o = out_last_q;
  assign stream_done_o = out_done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_done_o |-> last_of_run_o)
    else $error("stream end without end of run");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != ErrNone) |-> (data_byte_o == 8'd0))
    else $error("error beat carries data");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && (cur_pad_q != 2'd0) |-> (cur_err_q == ErrNone))
    else $error("padding on an error command");

endmodule

// File: hw/rtl/ascii85_decoder_unit.sv
// ascii85_decoder_unit: top level of the ascii85 decoder
// front end, command queue and back end; depends on a85d_pkg, a85d_front,
// a85d_fifo and a85d_back
//
// One ascii85 character is taken per beat and can be accepted every cycle while
// the four-entry command queue has room; the front end does the multiply-by-85
// accumulate in the cycle of acceptance. The back end sends one result beat per
// cycle when out_ready allows; a full group or a 'z' gives four beats, an error
// one beat, and a final partial group first runs the padding multiply once per
// missing digit (one to three) before its bytes go out. The queue lets new
// characters enter while a result waits. There is no start-up pass after reset.
module ascii85_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic [1:0] error_code_o,
  output logic       last_of_run_o,
  output logic       stream_done_o
);
  import a85d_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  a85d_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_in_i       (char_in_i),
    .end_of_stream_i (end_of_stream_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  a85d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  a85d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o),
    .stream_done_o (stream_done_o)
  );

endmodule

// File: verif/tb.sv
// tb: self-checking testbench of ascii85_decoder_unit, random stalls on both channels
// a queue-fed character driver, a beat monitor and a built-in decode predictor
// depends on a85d_pkg and the decoder rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import a85d_pkg::*;

  localparam longint unsigned Radix = 85;
  localparam longint unsigned WordMax = 64'hFFFF_FFFF;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
  } char_beat_t;

  typedef struct {
    logic [7:0] data;
    err_code_e  err;
    logic       last;
    logic       done;
  } byte_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_in = 8'h00;
  logic       end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] data_byte;
  logic [1:0] error_code;
  logic       last_of_run;
  logic       stream_done;

  char_beat_t pending_chars[$];
  byte_beat_t decoded_q[$];

  logic [31:0] grp_value = '0;
  logic [2:0]  grp_digits = '0;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;
  int   errors = 0;

  ascii85_decoder_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_in_i      (char_in),
    .end_of_stream_i(end_of_stream),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .data_byte_o    (data_byte),
    .error_code_o   (error_code),
    .last_of_run_o  (last_of_run),
    .stream_done_o  (stream_done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void add_byte(logic [7:0] d, err_code_e e);
    decoded_q.push_back('{data: d, err: e, last: 1'b0, done: 1'b0});
  endfunction

  // expected beats of one accepted character
  function automatic void decode_char(logic [7:0] ch, logic eos);
    longint unsigned acc;
    logic [31:0]     w;
    int              cnt;
    int              n0;
    n0 = decoded_q.size();
    if (ch == ZeroGroup && grp_digits == 0) begin
      repeat (4) add_byte(8'h00, ErrNone);
      grp_value = '0;
      grp_digits = '0;
    end else if (ch < DigitLow || ch > DigitHigh) begin
      add_byte(8'h00, ErrInvalid);
      grp_value = '0;
      grp_digits = '0;
    end else begin
      acc = longint'(grp_value) * Radix + longint'(ch - DigitLow);
      cnt = grp_digits + 1;
      if (cnt == 5 || eos) begin
        if (cnt == 1) begin
          add_byte(8'h00, ErrLone);
        end else begin
          for (int j = cnt; j < 5; j++) acc = acc * Radix + longint'(DigitHigh - DigitLow);
          if (acc > WordMax) begin
            add_byte(8'h00, ErrOverflow);
          end else begin
            w = acc[31:0];
            for (int b = 0; b < cnt - 1 || (cnt == 5 && b < 4); b++) begin
              add_byte(8'(w >> (24 - 8 * b)), ErrNone);
            end
          end
        end
        grp_value = '0;
        grp_digits = '0;
      end else begin
        grp_value = acc[31:0];
        grp_digits = 3'(cnt);
      end
    end
    if (eos) begin
      grp_value = '0;
      grp_digits = '0;
    end
    if (decoded_q.size() > n0) begin
      decoded_q[decoded_q.size() - 1].last = 1'b1;
      decoded_q[decoded_q.size() - 1].done = eos;
    end
  endfunction

  function automatic void add_char(logic [7:0] ch, logic eos);
    pending_chars.push_back('{ch: ch, eos: eos});
  endfunction

  function automatic logic [7:0] word_digit(logic [31:0] w, int pos);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < 4 - pos; i++) p = p * Radix;
    return 8'(longint'(DigitLow) + (longint'(w) / p) % Radix);
  endfunction

  // first ndig digits of the encoding of w, eos on the last one if asked
  function automatic void add_word(logic [31:0] w, int ndig, bit eos);
    for (int i = 0; i < ndig; i++) add_char(word_digit(w, i), eos && i == ndig - 1);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_junk();
    if ($urandom_range(0, 2) == 0) return ZeroGroup;
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 32));
    return 8'($urandom_range(118, 255));
  endfunction

  always @(negedge clk) begin : drive_chars
    char_beat_t nxt;
    logic       nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_taken) begin
        nv = 1'b0;
        if ($urandom_range(0, 23) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 11);
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_chars.size() > 0) begin
          nxt = pending_chars.pop_front();
          char_in <= nxt.ch;
          end_of_stream <= nxt.eos;
          nv = 1'b1;
        end
      end
      in_valid <= nv;
    end
  end

  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (out_taken) begin
        if ($urandom_range(0, 23) == 0) out_calm = !out_calm;
        out_gap = out_calm ? 0 : $urandom_range(0, 11);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch_beats
    byte_beat_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (in_valid && in_ready) decode_char(char_in, end_of_stream);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected beat: data_byte %02h error_code %0d", data_byte, error_code);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (data_byte !== want.data) begin
            $error("data_byte: expected %02h, got %02h", want.data, data_byte);
            errors++;
          end
          if (error_code !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, error_code);
            errors++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
            errors++;
          end
          if (stream_done !== want.done) begin
            $error("stream_done: expected %0b, got %0b", want.done, stream_done);
            errors++;
          end
        end
      end
    end
  end

  initial begin : run
    int kind;
    int k;
    // directed part
    add_char(ZeroGroup, 1'b0);
    add_char(8'h00, 1'b1);
    add_char(8'hFF, 1'b0);
    add_char(8'h20, 1'b0);
    add_char(8'h76, 1'b0);
    add_word(32'hFFFF_FFFF, 5, 1'b1);
    repeat (5) add_char(DigitHigh, 1'b0);
    add_char(DigitLow, 1'b0);
    add_char(ZeroGroup, 1'b0);
    add_char(DigitLow, 1'b1);
    repeat (2) add_char(DigitHigh, 1'b0);
    pending_chars[pending_chars.size() - 1].eos = 1'b1;
    add_word(32'h8D3C_11A5, 4, 1'b1);
    add_char(ZeroGroup, 1'b1);
    // random part
    k = 310;
    while (pending_chars.size() < k) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        add_word(pick_word(), 5, $urandom_range(0, 7) == 0);
      end else if (kind < 62) begin
        add_char(ZeroGroup, $urandom_range(0, 7) == 0);
      end else if (kind < 72) begin
        for (int i = 0; i < 5; i++) begin
          add_char(8'($urandom_range(DigitLow, DigitHigh)), i == 4 && $urandom_range(0, 7) == 0);
        end
      end else if (kind < 84) begin
        add_word(pick_word(), $urandom_range(1, 4), 1'b1);
      end else if (kind < 92) begin
        add_word(pick_word(), $urandom_range(1, 4), 1'b0);
        add_char(pick_junk(), $urandom_range(0, 3) == 0);
      end else begin
        add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (pending_chars.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: ascii85_decoder_unit.f
hw/rtl/a85d_pkg.sv
hw/rtl/a85d_front.sv
hw/rtl/a85d_fifo.sv
hw/rtl/a85d_back.sv
hw/rtl/ascii85_decoder_unit.sv
verif/tb.sv
